### sv/ptrs_pkg.sv
// Shared constants and command codes for the propensity table roulette select core.
// No dependencies; imported by the core module.

package ptrs_pkg;

    // Default table geometry
    localparam int ENTRIES_DEF   = 1024;
    localparam int RATE_BITS_DEF = 32;

    // Fixed field widths
    localparam int CMD_W      = 3;
    localparam int FRAC_W     = 32;     // random fraction, Q0.32
    localparam int SCALE_W    = 17;     // scale register, Q1.16 (1.0 is SCALE_ONE)
    localparam int SCALE_FRAC = 16;     // fraction bits of the scale register
    localparam int CHUNK_W    = 16;     // digit width of the target multiply
    localparam int CFG_ADDR_W = 1;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 17'd65536;

    // Commands
    localparam logic [CMD_W-1:0] CMD_UPD_BOTH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_BOTH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPD_INT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_INT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UPD_EXT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SET_EXT  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SELECT   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RESUM    = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE  = 1'b1;

endpackage

### sv/propensity_table_roulette_select_core.sv
// Rate table with roulette-wheel selection: table memories, one shared multiplier, walk sequencer.
// Depends on ptrs_pkg for widths, command codes and register indexes.
//
// The target multiply works on K = ceil(grand total width / 16) digits (3 by default). One item
// at a time: busy stays high until the result strobe, and the next item may start in the strobe
// cycle. The walk reads one table entry per cycle from the table memory, which sets the rate.
// Results cannot be stalled. Reset (synchronous, active low) clears the sums and control
// registers, sets the active count to ENTRIES and the scale to 1.0, then a clearing pass
// zeroes the table while busy is high.

module propensity_table_roulette_select_core #(
    parameter int ENTRIES   = ptrs_pkg::ENTRIES_DEF,
    parameter int RATE_BITS = ptrs_pkg::RATE_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // command channel
    input  logic                                        start,
    output logic                                        busy,
    input  logic [ptrs_pkg::CMD_W-1:0]                  i_command,
    input  logic [$clog2(ENTRIES)-1:0]                  i_entry_index,
    input  logic [RATE_BITS-1:0]                        i_internal_rate,
    input  logic [RATE_BITS-1:0]                        i_external_rate,
    input  logic [ptrs_pkg::FRAC_W-1:0]                 i_random_fraction,
    // configuration write port
    input  logic                                        i_cfg_we,
    input  logic [ptrs_pkg::CFG_ADDR_W-1:0]             i_cfg_addr,
    input  logic [(($clog2(ENTRIES+1) > ptrs_pkg::SCALE_W) ?
                   $clog2(ENTRIES+1) : ptrs_pkg::SCALE_W)-1:0] i_cfg_data,
    // result channel
    output logic                                        o_done,
    output logic [$clog2(ENTRIES)-1:0]                  o_chosen_index,
    output logic [RATE_BITS+$clog2(ENTRIES)-1:0]        o_internal_total,
    output logic [RATE_BITS+$clog2(ENTRIES)-1:0]        o_external_total,
    output logic [RATE_BITS+$clog2(ENTRIES):0]          o_grand_total,
    output logic                                        o_status
);
    import ptrs_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int COMB_W = RATE_BITS + 1;
    localparam int SUM_W  = RATE_BITS + IDX_W;
    localparam int TOT_W  = SUM_W + 1;
    localparam int F_W    = FRAC_W + 1;                 // scaled fraction
    localparam int MUL_W  = F_W + SCALE_W;              // shared multiplier product
    localparam int PP_W   = F_W + CHUNK_W;              // one digit product
    localparam int K      = (TOT_W + CHUNK_W - 1) / CHUNK_W;
    localparam int K_W    = (K > 1) ? $clog2(K) : 1;
    localparam int PAD_W  = K * CHUNK_W;
    localparam int PA_W   = F_W + PAD_W;                // full target product
    localparam int TGT_W  = PA_W - FRAC_W;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_CLEAR  = 10'b00_0000_0010,
        ST_WR_RD  = 10'b00_0000_0100,
        ST_WR_WR  = 10'b00_0000_1000,
        ST_UP_SUM = 10'b00_0001_0000,
        ST_SCALE  = 10'b00_0010_0000,
        ST_FRAC   = 10'b00_0100_0000,
        ST_MUL    = 10'b00_1000_0000,
        ST_ACC    = 10'b01_0000_0000,
        ST_WALK   = 10'b10_0000_0000
    } t_state;

    // Control registers
    t_state                 r_state,  n_state;
    logic [CNT_W-1:0]       r_ptr,    n_ptr;
    logic                   r_q_vld,  n_q_vld;
    logic                   r_done,   n_done;
    logic [CNT_W-1:0]       r_active, n_active;
    logic [SCALE_W-1:0]     r_scale,  n_scale;
    logic [SUM_W-1:0]       r_isum,   n_isum;
    logic [SUM_W-1:0]       r_esum,   n_esum;
    logic [TOT_W-1:0]       r_csum,   n_csum;
    logic [IDX_W-1:0]       r_chosen, n_chosen;
    logic                   r_status, n_status;

    // Payload registers
    logic [CMD_W-1:0]       r_cmd,    n_cmd;
    logic [IDX_W-1:0]       r_idx,    n_idx;
    logic [RATE_BITS-1:0]   r_ri,     n_ri;
    logic [RATE_BITS-1:0]   r_re,     n_re;
    logic [IDX_W-1:0]       r_q_idx,  n_q_idx;
    logic                   r_q_last, n_q_last;
    logic [SUM_W-1:0]       r_acc_i,  n_acc_i;
    logic [SUM_W-1:0]       r_acc_e,  n_acc_e;
    logic [TOT_W-1:0]       r_acc_c,  n_acc_c;
    logic [F_W-1:0]         r_frac,   n_frac;
    logic [MUL_W-1:0]       r_prod,   n_prod;
    logic [PA_W-1:0]        r_pacc,   n_pacc;
    logic [K_W-1:0]         r_k,      n_k;
    logic                   r_rb_i,   n_rb_i;
    logic                   r_rb_e,   n_rb_e;
    logic                   r_sel,    n_sel;

    // Table memories and registered read data
    logic [RATE_BITS-1:0]   r_mem_int  [ENTRIES];
    logic [RATE_BITS-1:0]   r_mem_ext  [ENTRIES];
    logic [COMB_W-1:0]      r_mem_comb [ENTRIES];
    logic [RATE_BITS-1:0]   r_q_int;
    logic [RATE_BITS-1:0]   r_q_ext;
    logic [COMB_W-1:0]      r_q_comb;

    logic [IDX_W-1:0]       rd_addr;
    logic                   mem_we;
    logic [IDX_W-1:0]       wr_addr;
    logic [RATE_BITS-1:0]   wr_int;
    logic [RATE_BITS-1:0]   wr_ext;
    logic [COMB_W-1:0]      wr_comb;

    logic [CNT_W-1:0]       live;
    logic                   wr_i, wr_e, wr_upd;
    logic                   walk_go;
    logic [SCALE_W-1:0]     mul_b;
    logic [PAD_W-1:0]       csum_pad;
    logic [CHUNK_W-1:0]     chunk;
    logic [TGT_W-1:0]       target;
    logic [SUM_W-1:0]       acc_i_sum;
    logic [SUM_W-1:0]       acc_e_sum;
    logic [TOT_W-1:0]       acc_c_sum;

    // Clamp the active count to the table size
    assign live = (r_active > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : r_active;

    // Decode which parts a write command touches
    assign wr_i   = (r_cmd == CMD_UPD_BOTH) || (r_cmd == CMD_SET_BOTH) ||
                    (r_cmd == CMD_UPD_INT)  || (r_cmd == CMD_SET_INT);
    assign wr_e   = (r_cmd == CMD_UPD_BOTH) || (r_cmd == CMD_SET_BOTH) ||
                    (r_cmd == CMD_UPD_EXT)  || (r_cmd == CMD_SET_EXT);
    assign wr_upd = (r_cmd == CMD_UPD_BOTH) || (r_cmd == CMD_UPD_INT) ||
                    (r_cmd == CMD_UPD_EXT);

    // Shared multiplier operands: scale first, then one digit of the grand total per pass
    assign csum_pad = PAD_W'(r_csum);
    assign chunk    = csum_pad[r_k*CHUNK_W +: CHUNK_W];
    assign mul_b    = (r_state == ST_SCALE) ? r_scale : SCALE_W'(chunk);
    assign target   = r_pacc[PA_W-1:FRAC_W];

    // Running sums of the walk
    assign acc_i_sum = r_acc_i + SUM_W'(r_q_int);
    assign acc_e_sum = r_acc_e + SUM_W'(r_q_ext);
    assign acc_c_sum = r_acc_c + TOT_W'(r_q_comb);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_q_vld  = 1'b0;
        n_done   = 1'b0;
        n_active = r_active;
        n_scale  = r_scale;
        n_isum   = r_isum;
        n_esum   = r_esum;
        n_csum   = r_csum;
        n_chosen = r_chosen;
        n_status = r_status;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_ri     = r_ri;
        n_re     = r_re;
        n_q_idx  = r_q_idx;
        n_q_last = r_q_last;
        n_acc_i  = r_acc_i;
        n_acc_e  = r_acc_e;
        n_acc_c  = r_acc_c;
        n_frac   = r_frac;
        n_prod   = r_prod;
        n_pacc   = r_pacc;
        n_k      = r_k;
        n_rb_i   = r_rb_i;
        n_rb_e   = r_rb_e;
        n_sel    = r_sel;
        walk_go  = 1'b0;
        rd_addr  = r_ptr[IDX_W-1:0];
        mem_we   = 1'b0;
        wr_addr  = r_idx;
        wr_int   = '0;
        wr_ext   = '0;
        wr_comb  = '0;

        unique case (r_state)
            // Zero the table one entry per cycle
            ST_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = r_ptr[IDX_W-1:0];
                if (r_ptr == CNT_W'(ENTRIES - 1)) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            // Take an item and dispatch on its command
            ST_IDLE: begin
                if (start) begin
                    n_cmd    = i_command;
                    n_idx    = i_entry_index;
                    n_ri     = i_internal_rate;
                    n_re     = i_external_rate;
                    n_frac   = F_W'(i_random_fraction);
                    n_chosen = '0;
                    n_status = 1'b0;
                    priority if (i_command == CMD_SELECT) begin
                        if (live == '0) begin
                            n_done = 1'b1;
                        end else begin
                            n_state = ST_SCALE;
                        end
                    end else if (i_command == CMD_RESUM) begin
                        n_rb_i = 1'b1;
                        n_rb_e = 1'b1;
                        if (live == '0) begin
                            n_isum = '0;
                            n_esum = '0;
                            n_csum = '0;
                            n_done = 1'b1;
                        end else begin
                            n_sel   = 1'b0;
                            walk_go = 1'b1;
                        end
                    end else if (CNT_W'(i_entry_index) >= live) begin
                        n_status = 1'b1;
                        n_done   = 1'b1;
                    end else begin
                        n_state = ST_WR_RD;
                    end
                end
            end

            // Fetch the old rates of the entry
            ST_WR_RD: begin
                rd_addr = r_idx;
                n_state = ST_WR_WR;
            end

            // Write the entry; adjust sums by the difference or start a rebuild
            ST_WR_WR: begin
                mem_we  = 1'b1;
                wr_int  = wr_i ? r_ri : r_q_int;
                wr_ext  = wr_e ? r_re : r_q_ext;
                wr_comb = COMB_W'(wr_int) + COMB_W'(wr_ext);
                if (wr_upd) begin
                    if (wr_i) begin
                        n_isum = r_isum - SUM_W'(r_q_int) + SUM_W'(r_ri);
                    end
                    if (wr_e) begin
                        n_esum = r_esum - SUM_W'(r_q_ext) + SUM_W'(r_re);
                    end
                    n_state = ST_UP_SUM;
                end else begin
                    n_rb_i  = wr_i;
                    n_rb_e  = wr_e;
                    n_sel   = 1'b0;
                    walk_go = 1'b1;
                end
            end

            // Grand total after an update
            ST_UP_SUM: begin
                n_csum  = TOT_W'(r_isum) + TOT_W'(r_esum);
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end

            // Scale the random fraction
            ST_SCALE: begin
                n_prod  = MUL_W'(r_frac) * MUL_W'(mul_b);
                n_state = ST_FRAC;
            end

            // Keep the scaled fraction and clear the target product
            ST_FRAC: begin
                n_frac  = r_prod[SCALE_FRAC +: F_W];
                n_pacc  = '0;
                n_k     = K_W'(K - 1);
                n_state = ST_MUL;
            end

            // Multiply the fraction by one digit of the grand total, top digit first
            ST_MUL: begin
                n_prod  = MUL_W'(r_frac) * MUL_W'(mul_b);
                n_state = ST_ACC;
            end

            // Shift in the digit product
            ST_ACC: begin
                n_pacc = (r_pacc << CHUNK_W) + PA_W'(r_prod[PP_W-1:0]);
                if (r_k == '0) begin
                    n_sel   = 1'b1;
                    walk_go = 1'b1;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = ST_MUL;
                end
            end

            // Read one entry per cycle and fold in the entry read last cycle
            ST_WALK: begin
                if (r_ptr < live) begin
                    rd_addr  = r_ptr[IDX_W-1:0];
                    n_q_vld  = 1'b1;
                    n_q_idx  = r_ptr[IDX_W-1:0];
                    n_q_last = (r_ptr == live - 1'b1);
                    n_ptr    = r_ptr + 1'b1;
                end
                if (r_q_vld) begin
                    n_acc_i = acc_i_sum;
                    n_acc_e = acc_e_sum;
                    n_acc_c = acc_c_sum;
                    if (r_sel) begin
                        // stop at the first entry whose running sum reaches the target, or at the last entry
                        if (!(target > TGT_W'(acc_c_sum)) || r_q_last) begin
                            n_chosen = r_q_idx;
                            n_done   = 1'b1;
                            n_state  = ST_IDLE;
                        end
                    end else if (r_q_last) begin
                        if (r_rb_i) begin
                            n_isum = acc_i_sum;
                        end
                        if (r_rb_e) begin
                            n_esum = acc_e_sum;
                        end
                        n_csum  = acc_c_sum;
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Enter the walk from entry zero
        if (walk_go) begin
            n_state = ST_WALK;
            n_ptr   = '0;
            n_acc_i = '0;
            n_acc_e = '0;
            n_acc_c = '0;
        end

        // Configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ACTIVE: n_active = i_cfg_data[CNT_W-1:0];
                CFG_SCALE:  n_scale  = i_cfg_data[SCALE_W-1:0];
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_ptr    <= '0;
            r_q_vld  <= 1'b0;
            r_done   <= 1'b0;
            r_active <= CNT_W'(ENTRIES);
            r_scale  <= SCALE_ONE;
            r_isum   <= '0;
            r_esum   <= '0;
            r_csum   <= '0;
            r_chosen <= '0;
            r_status <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_q_vld  <= n_q_vld;
            r_done   <= n_done;
            r_active <= n_active;
            r_scale  <= n_scale;
            r_isum   <= n_isum;
            r_esum   <= n_esum;
            r_csum   <= n_csum;
            r_chosen <= n_chosen;
            r_status <= n_status;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_ri     <= n_ri;
        r_re     <= n_re;
        r_q_idx  <= n_q_idx;
        r_q_last <= n_q_last;
        r_acc_i  <= n_acc_i;
        r_acc_e  <= n_acc_e;
        r_acc_c  <= n_acc_c;
        r_frac   <= n_frac;
        r_prod   <= n_prod;
        r_pacc   <= n_pacc;
        r_k      <= n_k;
        r_rb_i   <= n_rb_i;
        r_rb_e   <= n_rb_e;
        r_sel    <= n_sel;
    end

    // Table memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_int[wr_addr]  <= wr_int;
            r_mem_ext[wr_addr]  <= wr_ext;
            r_mem_comb[wr_addr] <= wr_comb;
        end
        r_q_int  <= r_mem_int[rd_addr];
        r_q_ext  <= r_mem_ext[rd_addr];
        r_q_comb <= r_mem_comb[rd_addr];
    end

    // Outputs
    assign busy             = (r_state != ST_IDLE) || !i_rst_n;
    assign o_done           = r_done;
    assign o_chosen_index   = r_chosen;
    assign o_internal_total = r_isum;
    assign o_external_total = r_esum;
    assign o_grand_total    = r_csum;
    assign o_status         = r_status;

endmodule

### verif/testbench.sv
// Self-checking testbench for propensity_table_roulette_select_core: rate writes, resums,
// flagged indexes and roulette selects against an in-bench table predictor.
// Depends on ptrs_pkg and the core RTL; needs no files or arguments.
`timescale 1ns / 100ps

module testbench;
    import ptrs_pkg::*;

    localparam int N_ENTRIES  = ENTRIES_DEF;
    localparam int RATE_W     = RATE_BITS_DEF;
    localparam int IDX_W      = $clog2(N_ENTRIES);
    localparam int SUM_W      = RATE_W + IDX_W;
    localparam int TOT_W      = SUM_W + 1;
    localparam int CFG_W      = ($clog2(N_ENTRIES + 1) > SCALE_W) ?
                                $clog2(N_ENTRIES + 1) : SCALE_W;
    localparam int CYCLE_LIMIT = 2_500_000;

    typedef struct packed {
        logic [IDX_W-1:0] chosen;
        logic [SUM_W-1:0] internal_total;
        logic [SUM_W-1:0] external_total;
        logic [TOT_W-1:0] grand_total;
        logic             status;
    } t_table_view;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [CMD_W-1:0]      i_command;
    logic [IDX_W-1:0]      i_entry_index;
    logic [RATE_W-1:0]     i_internal_rate;
    logic [RATE_W-1:0]     i_external_rate;
    logic [FRAC_W-1:0]     i_random_fraction;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  o_done;
    logic [IDX_W-1:0]      o_chosen_index;
    logic [SUM_W-1:0]      o_internal_total;
    logic [SUM_W-1:0]      o_external_total;
    logic [TOT_W-1:0]      o_grand_total;
    logic                  o_status;

    // Predicted table contents, sums and registers
    bit [RATE_W-1:0]  int_rate  [N_ENTRIES];
    bit [RATE_W-1:0]  ext_rate  [N_ENTRIES];
    bit [RATE_W:0]    comb_rate [N_ENTRIES];
    bit [SUM_W-1:0]   int_total;
    bit [SUM_W-1:0]   ext_total;
    bit [TOT_W-1:0]   comb_total;
    bit [10:0]        active_reg = 11'(N_ENTRIES);
    bit [SCALE_W-1:0] scale_reg  = SCALE_ONE;

    t_table_view awaited_views [$];
    int unsigned mismatches;
    int unsigned n_items, n_selects, n_writes, n_flagged, n_resums, n_views;
    int unsigned cycle_count;

    propensity_table_roulette_select_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_entry_index     (i_entry_index),
        .i_internal_rate   (i_internal_rate),
        .i_external_rate   (i_external_rate),
        .i_random_fraction (i_random_fraction),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_chosen_index    (o_chosen_index),
        .o_internal_total  (o_internal_total),
        .o_external_total  (o_external_total),
        .o_grand_total     (o_grand_total),
        .o_status          (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Entries in use; an oversized register acts as the full table
    function automatic int unsigned table_span();
        return (active_reg > N_ENTRIES) ? N_ENTRIES : int'(active_reg);
    endfunction

    // Rebuild the requested sums by walking the active entries
    function automatic void rebuild_sums(input bit do_int, input bit do_ext);
        bit [SUM_W-1:0] si;
        bit [SUM_W-1:0] se;
        bit [TOT_W-1:0] sc;
        int unsigned    n;
        n  = table_span();
        si = '0;
        se = '0;
        sc = '0;
        for (int k = 0; k < n; k++) begin
            si += int_rate[k];
            se += ext_rate[k];
            sc += comb_rate[k];
        end
        if (do_int) int_total = si;
        if (do_ext) ext_total = se;
        comb_total = sc;
    endfunction

    // Scale the fraction, form the target in 16-bit digits, walk the cumulative rates
    function automatic bit [IDX_W-1:0] roulette_pick(input bit [FRAC_W-1:0] frac);
        bit [63:0]   f;
        bit [63:0]   target;
        bit [63:0]   acc;
        int unsigned n;
        int unsigned i;
        n = table_span();
        if (n == 0) return '0;
        f = (64'(frac) * 64'(scale_reg)) >> SCALE_FRAC;
        target = f * 64'(comb_total >> 32)
               + ((f * 64'(comb_total[31:16]) + ((f * 64'(comb_total[15:0])) >> 16)) >> 16);
        acc = 64'(comb_rate[0]);
        i   = 0;
        while (target > acc && i + 1 < n) begin
            i++;
            acc += 64'(comb_rate[i]);
        end
        return IDX_W'(i);
    endfunction

    // Apply one command to the predicted table and return the view it yields
    function automatic t_table_view compute_table_view(
        input bit [CMD_W-1:0]  cmd,
        input bit [IDX_W-1:0]  idx,
        input bit [RATE_W-1:0] ri,
        input bit [RATE_W-1:0] re,
        input bit [FRAC_W-1:0] frac
    );
        t_table_view v;
        bit wi, we, upd;
        v  = '0;
        wi = (cmd == CMD_UPD_BOTH || cmd == CMD_SET_BOTH ||
              cmd == CMD_UPD_INT  || cmd == CMD_SET_INT);
        we = (cmd == CMD_UPD_BOTH || cmd == CMD_SET_BOTH ||
              cmd == CMD_UPD_EXT  || cmd == CMD_SET_EXT);
        upd = (cmd == CMD_UPD_BOTH || cmd == CMD_UPD_INT || cmd == CMD_UPD_EXT);
        if (cmd == CMD_SELECT) begin
            v.chosen = roulette_pick(frac);
        end else if (cmd == CMD_RESUM) begin
            rebuild_sums(1'b1, 1'b1);
        end else if (idx >= table_span()) begin
            v.status = 1'b1;
        end else begin
            if (upd) begin
                if (wi) int_total = int_total - int_rate[idx] + ri;
                if (we) ext_total = ext_total - ext_rate[idx] + re;
                comb_total = TOT_W'(int_total) + TOT_W'(ext_total);
            end
            if (wi) int_rate[idx] = ri;
            if (we) ext_rate[idx] = re;
            comb_rate[idx] = (RATE_W + 1)'(int_rate[idx]) + (RATE_W + 1)'(ext_rate[idx]);
            if (!upd) rebuild_sums(wi, we);
        end
        v.internal_total = int_total;
        v.external_total = ext_total;
        v.grand_total    = comb_total;
        return v;
    endfunction

    // Drive one item from a falling edge and hold it until accepted
    task automatic send_item(
        input logic [CMD_W-1:0]  cmd,
        input logic [IDX_W-1:0]  idx,
        input logic [RATE_W-1:0] ri,
        input logic [RATE_W-1:0] re,
        input logic [FRAC_W-1:0] frac
    );
        start             <= 1'b1;
        i_command         <= cmd;
        i_entry_index     <= idx;
        i_internal_rate   <= ri;
        i_external_rate   <= re;
        i_random_fraction <= frac;
        do @(posedge i_clk); while (busy);
        awaited_views.push_back(compute_table_view(cmd, idx, ri, re, frac));
        n_items++;
        if (cmd == CMD_SELECT) n_selects++;
        else if (cmd == CMD_RESUM) n_resums++;
        else if (idx >= table_span()) n_flagged++;
        else n_writes++;
        @(negedge i_clk);
    endtask

    // Drop start and idle for a number of cycles
    task automatic hold_off(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Write a register once every item has drained
    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_W-1:0] data);
        start <= 1'b0;
        while (awaited_views.size() != 0 || busy) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            CFG_ACTIVE: active_reg = data[10:0];
            CFG_SCALE:  scale_reg  = data[SCALE_W-1:0];
            default:    ;
        endcase
    endtask

    // Mostly no gap, some short, a few long
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [RATE_W-1:0] draw_rate();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return RATE_W'($urandom_range(0, 32'h000F_FFFF));
            default: return RATE_W'($urandom);
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] draw_fraction();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 13) return '1;
        return $urandom;
    endfunction

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_table_view want;
        if (i_rst_n && o_done) begin
            if (awaited_views.size() == 0) begin
                $error("result strobe with no item outstanding");
                mismatches++;
            end else begin
                want = awaited_views.pop_front();
                n_views++;
                if (o_chosen_index !== want.chosen) begin
                    $error("chosen_index: expected %0d, got %0d", want.chosen, o_chosen_index);
                    mismatches++;
                end
                if (o_internal_total !== want.internal_total) begin
                    $error("internal_total: expected %0h, got %0h",
                           want.internal_total, o_internal_total);
                    mismatches++;
                end
                if (o_external_total !== want.external_total) begin
                    $error("external_total: expected %0h, got %0h",
                           want.external_total, o_external_total);
                    mismatches++;
                end
                if (o_grand_total !== want.grand_total) begin
                    $error("grand_total: expected %0h, got %0h",
                           want.grand_total, o_grand_total);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    // Empty table, all-ones and zero rates, first and last entries, fraction extremes
    task automatic test_table_extremes();
        send_item(CMD_SELECT,   '0,  '0,             '0,             '0);
        send_item(CMD_RESUM,    '0,  '0,             '0,             '0);
        send_item(CMD_SET_BOTH, '0,  '1,             '1,             '0);
        send_item(CMD_UPD_BOTH, '1,  '1,             '0,             '1);
        send_item(CMD_UPD_INT,  512, 32'h0001_0000,  '1,             '0);
        send_item(CMD_SET_INT,  1,   32'h0002_0000,  '0,             '0);
        send_item(CMD_UPD_EXT,  2,   '0,             '1,             '0);
        send_item(CMD_SET_EXT,  '1,  '0,             32'h5555_AAAA,  '0);
        send_item(CMD_SELECT,   '0,  '0,             '0,             '1);
        send_item(CMD_SELECT,   '1,  '0,             '0,             '0);
        send_item(CMD_SELECT,   '0,  '0,             '0,             32'h8000_0000);
        send_item(CMD_RESUM,    '1,  '1,             '1,             '1);
    endtask

    // Writes past the active range are flagged; sums stay stale until a resum
    task automatic test_flagged_index();
        write_register(CFG_ACTIVE, 8);
        send_item(CMD_UPD_BOTH, 8,   32'h0003_0000,  32'h0004_0000,  '0);
        send_item(CMD_SET_EXT,  '1,  '0,             '1,             '0);
        send_item(CMD_UPD_INT,  7,   32'hAAAA_5555,  '0,             '0);
        send_item(CMD_SELECT,   '0,  '0,             '0,             '1);
        send_item(CMD_RESUM,    '0,  '0,             '0,             '0);
    endtask

    // Zero and oversized active counts, single entry, zero scale
    task automatic test_register_corners();
        write_register(CFG_ACTIVE, 0);
        send_item(CMD_SET_BOTH, '0,  '1,             '1,             '0);
        send_item(CMD_RESUM,    '0,  '0,             '0,             '0);
        send_item(CMD_SELECT,   '0,  '0,             '0,             '1);
        write_register(CFG_ACTIVE, 2000);
        send_item(CMD_RESUM,    '0,  '0,             '0,             '0);
        send_item(CMD_SELECT,   '0,  '0,             '0,             32'h4000_0000);
        write_register(CFG_ACTIVE, 1);
        write_register(CFG_SCALE,  0);
        send_item(CMD_SELECT,   '0,  '0,             '0,             '1);
        send_item(CMD_UPD_EXT,  '0,  '0,             32'h0000_8000,  '0);
    endtask

    // Phases of random commands under different table sizes and scales
    task automatic test_random_traffic();
        int unsigned      span_list [10];
        int unsigned      span, count, r, gap;
        bit               burst;
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] scale;
        span_list[0] = 1024; span_list[1] = 5;    span_list[2] = 64;  span_list[3] = 1;
        span_list[4] = 17;   span_list[5] = 2000; span_list[6] = 200; span_list[7] = 3;
        span_list[8] = 1024; span_list[9] = 40;
        for (int p = 0; p < 10; p++) begin
            case (p % 5)
                0:       scale = CFG_W'(SCALE_ONE);
                1:       scale = '0;
                2:       scale = CFG_W'($urandom_range(1, 65535));
                3:       scale = CFG_W'(32768);
                default: scale = CFG_W'($urandom_range(60000, 65536));
            endcase
            write_register(CFG_ACTIVE, CFG_W'(span_list[p]));
            write_register(CFG_SCALE, scale);
            span  = table_span();
            count = (span >= N_ENTRIES) ? 35 : 65;
            burst = (p % 3 == 1);
            repeat (count) begin
                if (!burst) begin
                    gap = draw_gap();
                    if (gap != 0) hold_off(gap);
                end
                r = $urandom_range(0, 99);
                if      (r < 12) cmd = CMD_UPD_BOTH;
                else if (r < 20) cmd = CMD_SET_BOTH;
                else if (r < 32) cmd = CMD_UPD_INT;
                else if (r < 38) cmd = CMD_SET_INT;
                else if (r < 50) cmd = CMD_UPD_EXT;
                else if (r < 56) cmd = CMD_SET_EXT;
                else if (r < 92) cmd = CMD_SELECT;
                else             cmd = CMD_RESUM;
                // keep most writes inside the active range
                if ($urandom_range(0, 99) < 80)
                    idx = IDX_W'($urandom_range(0, span - 1));
                else
                    idx = IDX_W'($urandom_range(0, N_ENTRIES - 1));
                send_item(cmd, idx, draw_rate(), draw_rate(), draw_fraction());
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_command         = '0;
        i_entry_index     = '0;
        i_internal_rate   = '0;
        i_external_rate   = '0;
        i_random_fraction = '0;
        i_cfg_we          = 1'b0;
        i_cfg_addr        = '0;
        i_cfg_data        = '0;
        mismatches        = 0;
        cycle_count       = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_table_extremes();
        test_flagged_index();
        test_register_corners();
        test_random_traffic();

        // Drain outstanding results, then allow a short tail
        start <= 1'b0;
        while (awaited_views.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Ran %0d items (%0d results checked): %0d selects, %0d table writes,",
                 n_items, n_views, n_selects, n_writes);
        $display("  %0d out-of-range writes, %0d resums; %0d mismatches",
                 n_flagged, n_resums, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
